// ===== rtl/core/crb_pkg.sv =====
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types, constants and helpers of the reflect-101 border convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package crb_pkg;

    localparam int KSIZE     = 3;
    localparam int KTAPS     = KSIZE * KSIZE;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int POS_W     = 13;
    localparam int SUM_W     = 30;
    localparam int PROD_W    = 27;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_COEF  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    typedef logic [7:0] pix_t;
    typedef logic signed [17:0] coef_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // index 0 is the top row of the window column
    typedef pix_t [2:0] col_t;
    typedef pix_t [KTAPS-1:0] win_t;
    typedef coef_t [KTAPS-1:0] kern_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last;
        logic               fdone;
    } res_t;

    // tap x*K+y weighs window row K-1-x, column K-1-y
    function automatic win_t build_win(input col_t left, input col_t center, input col_t right);
        col_t  cols [3];
        win_t  w;
        cols[0] = left;
        cols[1] = center;
        cols[2] = right;
        for (int x = 0; x < KSIZE; x++) begin
            for (int y = 0; y < KSIZE; y++) begin
                w[x*KSIZE+y] = cols[KSIZE-1-y][KSIZE-1-x];
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crb_cell.sv =====
// ----------------------------------------------------------------------------
// crb_cell
// One window column: holds three pixels and hands them on at each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_cell (
    input  wire logic          clk,
    input  wire logic          shift_en,
    input  wire crb_pkg::col_t col_in,
    output crb_pkg::col_t      col_out
);
    import crb_pkg::*;

    col_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crb_mac.sv =====
// ----------------------------------------------------------------------------
// crb_mac
// Window dot product: registered products, then registered sum.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_mac (
    input  wire logic           clk,
    input  wire crb_pkg::win_t  win,
    input  wire crb_pkg::kern_t kern,
    output crb_pkg::sum_t       sum
);
    import crb_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [KTAPS];
    sum_t sum_next;
    sum_t sum_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KTAPS; i++)
        begin
            prod_reg[i] <= $signed({1'b0, win[i]}) * $signed(kern[i]);
        end
        sum_reg <= sum_next;
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < KTAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[i]);
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/conv2d_reflect_border.sv =====
// Pipeline: each beat is registered in stage 1, its window in the MAC product and sum
// registers, and its results in a 16-entry result queue that backs up the input.
// Throughput: one input beat per cycle while in_ready is high; the last beat of each row
// after the first yields two results, drained one per cycle while out_ready is high.
// Line store: three 1024x8 banks, one per ring row, one write and one read per cycle.
// Reset: position, flush count, coefficients, configuration, valid flags and queue
// pointers return to defaults; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
// conv2d_reflect_border
// Streaming 3x3 convolution with reflect-101 borders over 8-bit grey pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_reflect_border (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_en,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [12:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [7:0]                    pixel,
    input  wire logic [5:0]                    coef_index,
    input  wire logic signed [17:0]            coef_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 result_value,
    output logic [11:0]                        out_row,
    output logic [9:0]                         out_col,
    output logic                               last_in_run,
    output logic                               frame_done
);
    import crb_pkg::*;

    // configuration
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        mode_reg;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [10:0] w_m1;
    kern_t       coef_reg;

    // input position
    logic [POS_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] flush_reg;
    logic [1:0]       ptr_reg;

    logic             acc;
    logic             is_pix;
    logic             is_fl;
    logic             act;
    logic [COL_W-1:0] pc;
    logic             last_col;

    // line store banks
    pix_t bank0 [MAX_WIDTH];
    pix_t bank1 [MAX_WIDTH];
    pix_t bank2 [MAX_WIDTH];
    pix_t rd_reg [3];

    // stage 1
    logic             s1_act_reg;
    logic             s1_v_reg;
    logic             s1_first_reg;
    logic             s1_flush_reg;
    logic             s1_last_reg;
    logic             s1_fd_reg;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_pc_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [1:0]       s1_top_reg;
    logic [1:0]       s1_mid_reg;

    col_t ncol;
    col_t p1;
    col_t p2;
    win_t win_a;
    win_t win_b;
    logic va;
    logic vb;

    // stages 2 and 3
    logic             s2_va_reg, s2_vb_reg, s2_fd_reg;
    logic             s3_va_reg, s3_vb_reg, s3_fd_reg;
    logic [ROW_W-1:0] s2_row_reg, s3_row_reg;
    logic [COL_W-1:0] s2_pc_reg, s3_pc_reg;
    sum_t             sum_a;
    sum_t             sum_b;

    // result queue
    res_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg;
    logic [FIFO_AW-1:0] rp_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;
    logic [1:0]         npush;
    logic               pop;
    res_t               res_a;
    res_t               res_b;
    logic [FIFO_AW+1:0] reserve;

    assign w_eff = (width_reg < 11'd4) ? 11'd4 :
                   (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg < 13'd4) ? 13'd4 :
                   (height_reg > 13'd4096) ? 13'd4096 : height_reg;
    assign w_m1  = w_eff - 11'd1;

    assign acc    = in_valid && in_ready;
    assign is_pix = (req_type == REQ_PIXEL) && (in_row_reg < h_eff);
    assign is_fl  = (req_type == REQ_FLUSH) && (in_row_reg >= h_eff);
    assign act    = acc && (is_pix || is_fl);
    assign pc     = is_pix ? in_col_reg : flush_reg;
    assign last_col = ({1'b0, pc} == w_m1);

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            mode_reg   <= 1'b0;
            coef_reg   <= '0;
            in_row_reg <= '0;
            in_col_reg <= '0;
            flush_reg  <= '0;
            ptr_reg    <= '0;
        end
        else if (cfg_en && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT))
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_reg <= cfg_data[10:0];
            end
            else
            begin
                height_reg <= cfg_data;
            end
            in_row_reg <= '0;
            in_col_reg <= '0;
            flush_reg  <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            if (cfg_en && cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            if (acc && req_type == REQ_COEF && coef_index < 6'(KTAPS))
            begin
                coef_reg[coef_index[3:0]] <= coef_value;
            end
            if (act && is_pix)
            begin
                if (last_col)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 13'd1;
                    ptr_reg    <= (ptr_reg == 2'd2) ? 2'd0 : ptr_reg + 2'd1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 10'd1;
                end
            end
            else if (act)
            begin
                // one phantom row closes the frame
                if (last_col)
                begin
                    in_row_reg <= '0;
                    in_col_reg <= '0;
                    flush_reg  <= '0;
                    ptr_reg    <= '0;
                end
                else
                begin
                    flush_reg <= flush_reg + 10'd1;
                end
            end
        end
    end

    // line store: write the current ring row, read all rows at this column
    always_ff @(posedge clk)
    begin
        if (act && is_pix && ptr_reg == 2'd0)
        begin
            bank0[in_col_reg] <= pixel;
        end
        if (act && is_pix && ptr_reg == 2'd1)
        begin
            bank1[in_col_reg] <= pixel;
        end
        if (act && is_pix && ptr_reg == 2'd2)
        begin
            bank2[in_col_reg] <= pixel;
        end
        rd_reg[0] <= bank0[pc];
        rd_reg[1] <= bank1[pc];
        rd_reg[2] <= bank2[pc];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_act_reg <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_va_reg  <= 1'b0;
            s2_vb_reg  <= 1'b0;
            s3_va_reg  <= 1'b0;
            s3_vb_reg  <= 1'b0;
        end
        else
        begin
            s1_act_reg <= act;
            s1_v_reg   <= act && (is_fl || in_row_reg != '0);
            s2_va_reg  <= va;
            s2_vb_reg  <= vb;
            s3_va_reg  <= s2_va_reg;
            s3_vb_reg  <= s2_vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= is_pix && (in_row_reg == 13'd1);
        s1_flush_reg <= is_fl;
        s1_last_reg  <= last_col;
        s1_fd_reg    <= is_fl && last_col;
        s1_pix_reg   <= pixel;
        s1_pc_reg    <= pc;
        s1_row_reg   <= is_pix ? ROW_W'(in_row_reg - 13'd1) : ROW_W'(h_eff - 13'd1);
        s1_top_reg   <= (ptr_reg == 2'd2) ? 2'd0 : ptr_reg + 2'd1;
        s1_mid_reg   <= (ptr_reg == 2'd0) ? 2'd2 : ptr_reg - 2'd1;
        s2_fd_reg    <= s1_fd_reg;
        s2_row_reg   <= s1_row_reg;
        s2_pc_reg    <= s1_pc_reg;
        s3_fd_reg    <= s2_fd_reg;
        s3_row_reg   <= s2_row_reg;
        s3_pc_reg    <= s2_pc_reg;
    end

    // new column with row mirroring at the top and bottom edges
    always_comb
    begin
        ncol[0] = rd_reg[s1_top_reg];
        ncol[1] = rd_reg[s1_mid_reg];
        ncol[2] = s1_pix_reg;
        if (s1_first_reg)
        begin
            ncol[0] = s1_pix_reg;
        end
        if (s1_flush_reg)
        begin
            ncol[2] = ncol[0];
        end
    end

    crb_cell u_cell1 (
        .clk      (clk),
        .shift_en (s1_act_reg),
        .col_in   (ncol),
        .col_out  (p1)
    );

    crb_cell u_cell2 (
        .clk      (clk),
        .shift_en (s1_act_reg),
        .col_in   (p1),
        .col_out  (p2)
    );

    assign va    = s1_v_reg && (s1_pc_reg != '0);
    assign vb    = s1_v_reg && s1_last_reg;
    assign win_a = build_win((s1_pc_reg == 10'd1) ? ncol : p2, p1, ncol);
    assign win_b = build_win(p1, ncol, p1);

    crb_mac u_mac_a (
        .clk  (clk),
        .win  (win_a),
        .kern (coef_reg),
        .sum  (sum_a)
    );

    crb_mac u_mac_b (
        .clk  (clk),
        .win  (win_b),
        .kern (coef_reg),
        .sum  (sum_b)
    );

    function automatic logic signed [31:0] fmt(input sum_t s, input logic wide);
        logic [SUM_W-1:0] mag;
        logic [15:0]      ip;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        ip  = mag[SUM_W-1:14];
        if (wide)
        begin
            return 32'(s);
        end
        return (ip > 16'd255) ? 32'sd255 : $signed({16'd0, ip});
    endfunction

    always_comb
    begin
        res_a.value = fmt(sum_a, mode_reg);
        res_a.row   = s3_row_reg;
        res_a.col   = s3_pc_reg - 10'd1;
        res_a.last  = !s3_vb_reg;
        res_a.fdone = 1'b0;
        res_b.value = fmt(sum_b, mode_reg);
        res_b.row   = s3_row_reg;
        res_b.col   = s3_pc_reg;
        res_b.last  = 1'b1;
        res_b.fdone = s3_fd_reg;
    end

    assign npush = {1'b0, s3_va_reg} + {1'b0, s3_vb_reg};
    assign pop   = out_valid && out_ready;
    assign cnt_next = cnt_reg + (FIFO_AW+1)'(npush) - (FIFO_AW+1)'(pop);

    // hold room for two results per beat still in flight
    assign reserve = (FIFO_AW+2)'(cnt_reg)
                   + (FIFO_AW+2)'({s1_v_reg, 1'b0})
                   + (FIFO_AW+2)'({s2_va_reg || s2_vb_reg, 1'b0})
                   + (FIFO_AW+2)'({s3_va_reg || s3_vb_reg, 1'b0})
                   + (FIFO_AW+2)'(2);
    assign in_ready = (reserve <= (FIFO_AW+2)'(FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (s3_va_reg)
        begin
            fifo_mem[wp_reg] <= res_a;
            if (s3_vb_reg)
            begin
                fifo_mem[wp_reg + 4'd1] <= res_b;
            end
        end
        else if (s3_vb_reg)
        begin
            fifo_mem[wp_reg] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + FIFO_AW'(npush);
            rp_reg  <= rp_reg + FIFO_AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    assign out_valid    = (cnt_reg != '0);
    assign result_value = fifo_mem[rp_reg].value;
    assign out_row      = fifo_mem[rp_reg].row;
    assign out_col      = fifo_mem[rp_reg].col;
    assign last_in_run  = fifo_mem[rp_reg].last;
    assign frame_done   = fifo_mem[rp_reg].fdone;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overrun");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, in_col_reg} < w_eff)
        else $error("input column beyond row width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= h_eff)
        else $error("input row beyond frame end");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (va && vb) |=> (s2_va_reg && s2_vb_reg))
        else $error("row end pair split");

endmodule

`default_nettype wire

// ===== tb/conv2d_reflect_border_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d_reflect_border_test
// Self-checking bench for the 3x3 reflect-101 border convolution. A scoreboard
// class mirrors the line store, kernel and raster position, predicts every
// filtered pixel per accepted beat and checks results in order as they leave.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_reflect_border_test;
    import crb_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [1:0] CFG_NONE = 2'd3;

    class conv_scoreboard;
        byte unsigned line_mem [3][MAX_WIDTH];
        coef_t        kern [KTAPS];
        int unsigned  row_pos, col_pos, flush_cnt;
        int unsigned  reg_w, reg_h;
        bit           wide_mode;
        res_t         expected_q [$];
        int           errors;
        int           checked;

        function new();
            foreach (kern[i]) kern[i] = '0;
            row_pos = 0; col_pos = 0; flush_cnt = 0;
            reg_w = 640; reg_h = 480; wide_mode = 0;
            errors = 0; checked = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int unsigned eff_w();
            if (reg_w < 4) return 4;
            if (reg_w > MAX_WIDTH) return MAX_WIDTH;
            return reg_w;
        endfunction

        function int unsigned eff_h();
            if (reg_h < 4) return 4;
            if (reg_h > 4096) return 4096;
            return reg_h;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                CFG_WIDTH:  reg_w = val[10:0];
                CFG_HEIGHT: reg_h = val;
                CFG_MODE:
                begin
                    wide_mode = val[0];
                    return;
                end
                default: return;
            endcase
            row_pos = 0; col_pos = 0; flush_cnt = 0;
        endfunction

        // reflect-101: -1 reads 1, n reads n-2
        function int mirror(int p, int n);
            if (p < 0) p = -p;
            if (p >= n) p = 2 * n - 2 - p;
            if (p < 0) p = 0;
            if (p >= n) p = n - 1;
            return p;
        endfunction

        function logic signed [31:0] filter_pixel(int r, int c, int w, int h);
            longint acc;
            int pr, pc;
            acc = 0;
            for (int x = 0; x < KSIZE; x++) begin
                pr = mirror(r + 1 - x, h);
                for (int y = 0; y < KSIZE; y++) begin
                    pc = mirror(c + 1 - y, w);
                    acc += longint'(line_mem[pr % 3][pc]) * longint'(kern[x * KSIZE + y]);
                end
            end
            if (wide_mode) begin
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                return acc[31:0];
            end
            if (acc < 0) acc = -acc;
            acc = acc >>> 14;
            if (acc > 255) acc = 255;
            return acc[31:0];
        endfunction

        function void note_input(logic [1:0] rq, pix_t pix, logic [5:0] idx, coef_t val);
            int unsigned w, h, pr, pc, orow;
            int unsigned cols [$];
            res_t r;
            w = eff_w();
            h = eff_h();
            if (col_pos >= w || row_pos > h) begin
                row_pos = 0; col_pos = 0; flush_cnt = 0;
            end
            case (rq)
                REQ_COEF:
                begin
                    if (idx < KTAPS) kern[idx] = val;
                    return;
                end
                REQ_PIXEL:
                begin
                    if (row_pos >= h) return;
                    line_mem[row_pos % 3][col_pos] = pix;
                    pr = row_pos;
                    pc = col_pos;
                    col_pos++;
                    if (col_pos == w) begin
                        col_pos = 0;
                        row_pos++;
                    end
                end
                REQ_FLUSH:
                begin
                    if (row_pos < h) return;
                    pr = h + flush_cnt / w;
                    pc = flush_cnt % w;
                    flush_cnt++;
                    if (flush_cnt >= w) begin
                        row_pos = 0; col_pos = 0; flush_cnt = 0;
                    end
                end
                default: return;
            endcase
            if (pr < 1) return;
            orow = pr - 1;
            if (pc >= 1) cols.push_back(pc - 1);
            if (pc == w - 1) cols.push_back(w - 1);
            foreach (cols[k]) begin
                r.value = filter_pixel(orow, cols[k], w, h);
                r.row   = orow[ROW_W-1:0];
                r.col   = cols[k][COL_W-1:0];
                r.last  = (k == cols.size() - 1);
                r.fdone = (orow == h - 1 && cols[k] == w - 1);
                expected_q.push_back(r);
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
            errors++;
        endtask

        task check_result(res_t got);
            res_t want;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, row", got.row, -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
            if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
            if (got.col !== want.col) report_mismatch("out_col", got.col, want.col);
            if (got.last !== want.last) report_mismatch("last_in_run", got.last, want.last);
            if (got.fdone !== want.fdone) report_mismatch("frame_done", got.fdone, want.fdone);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_PIXEL;
    logic [7:0]  pixel = '0;
    logic [5:0]  coef_index = '0;
    logic signed [17:0] coef_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] result_value;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_in_run;
    logic        frame_done;

    conv_scoreboard sb = new();
    int  tx_idle_pct = 19;
    int  rx_idle_pct = 65;
    bit  rx_hold = 1'b0;
    int  beats_sent = 0;
    int  frames_sent = 0;
    int  quiet_cycles = 0;

    conv2d_reflect_border dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .pixel(pixel), .coef_index(coef_index), .coef_value(coef_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .out_row(out_row), .out_col(out_col),
        .last_in_run(last_in_run), .frame_done(frame_done)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // sample at the falling edge; the beat completes at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{result_value, out_row, out_col, last_in_run, frame_done});
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a rising edge; returns at the rising edge that takes the beat
    task automatic send_beat(logic [1:0] rq, pix_t pix, logic [5:0] idx, coef_t val);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        pixel      <= pix;
        coef_index <= idx;
        coef_value <= val;
        do @(negedge clk); while (!in_ready);
        sb.note_input(rq, pix, idx, val);
        beats_sent++;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_en    <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic coef_t rand_coef();
        case ($urandom_range(3))
            0: return coef_t'($urandom);
            1: return coef_t'($urandom_range(0, 32768)) - 18'sd16384;
            2: return coef_t'($urandom_range(0, 4096));
            default: return $urandom_range(1) ? 18'sh1ffff : 18'sh20000;
        endcase
    endfunction

    task automatic load_kernel();
        for (int i = 0; i < KTAPS; i++) send_beat(REQ_COEF, 8'($urandom), 6'(i), rand_coef());
    endtask

    // one frame of pixels with rare noise beats, then the flush row
    task automatic run_frame(int w, int h, int noise_pct);
        int r;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                r = $urandom_range(2);
                if (r == 0)
                    send_beat(REQ_FLUSH, 8'($urandom), 6'($urandom), coef_t'($urandom));
                else if (r == 1)
                    send_beat(REQ_NONE, 8'($urandom), 6'($urandom), coef_t'($urandom));
                else
                    send_beat(REQ_COEF, 8'($urandom), 6'($urandom_range(63)), rand_coef());
            end
            send_beat(REQ_PIXEL, 8'($urandom), 6'($urandom), coef_t'($urandom));
        end
        if ($urandom_range(99) < noise_pct)
            send_beat(REQ_PIXEL, 8'($urandom), 6'($urandom), coef_t'($urandom));
        for (int i = 0; i < w; i++)
            send_beat(REQ_FLUSH, 8'($urandom), 6'($urandom), coef_t'($urandom));
        frames_sent++;
    endtask

    task automatic random_frames(int target);
        int w, h;
        while (beats_sent < target) begin
            drain();
            w = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(4, 8);
            h = ($urandom_range(9) == 0) ? $urandom_range(0, 12) : $urandom_range(4, 6);
            write_reg(CFG_WIDTH, 13'(w));
            write_reg(CFG_HEIGHT, 13'(h));
            write_reg(CFG_MODE, 13'($urandom_range(1)));
            if ($urandom_range(2) == 0) load_kernel();
            if ($urandom_range(7) == 0) begin
                // abandon a frame after up to ten pixels; the geometry write restarts it
                repeat ($urandom_range(1, 10)) send_beat(REQ_PIXEL, 8'($urandom), 0, 0);
                drain();
                write_reg(CFG_WIDTH, 13'(w));
            end
            run_frame(sb.eff_w(), sb.eff_h(), 6);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme coefficients, ignored requests, smallest frame
        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'd0);
        write_reg(CFG_NONE, 13'h1fff);
        send_beat(REQ_COEF, 8'hff, 6'd4, 18'sh1ffff);
        send_beat(REQ_COEF, 8'h00, 6'd0, 18'sh20000);
        send_beat(REQ_COEF, 8'h00, 6'd8, 18'sd16384);
        send_beat(REQ_COEF, 8'h00, 6'd63, 18'sh3ffff);
        send_beat(REQ_NONE, 8'hff, 6'h3f, 18'sh3ffff);
        send_beat(REQ_FLUSH, 8'h00, 6'd0, 18'sd0);
        for (int i = 0; i < 16; i++) send_beat(REQ_PIXEL, (i % 3 == 0) ? 8'hff : 8'h00, 0, 0);
        send_beat(REQ_PIXEL, 8'h80, 0, 0);
        for (int i = 0; i < 4; i++) send_beat(REQ_FLUSH, 0, 0, 0);
        drain();

        // tallest height clamp and wide mode with a partial frame
        write_reg(CFG_HEIGHT, 13'h1fff);
        write_reg(CFG_MODE, 13'd1);
        repeat (12) send_beat(REQ_PIXEL, 8'($urandom), 0, 0);
        drain();

        random_frames(200);

        tx_idle_pct = 65;
        rx_idle_pct = 19;
        drain();
        write_reg(CFG_WIDTH, 13'd6);
        write_reg(CFG_HEIGHT, 13'd5);
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none
        run_frame(6, 5, 0);
        random_frames(350);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_frames(450);

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d input beats over %0d frames, %0d results checked",
                 beats_sent, frames_sent, sb.checked);
        $display("widths 4..40 with clamped geometry, both output modes, idle and stall phases");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/crb_pkg.sv
rtl/core/crb_cell.sv
rtl/core/crb_mac.sv
rtl/core/conv2d_reflect_border.sv
tb/conv2d_reflect_border_test.sv
